// File: hdl/tlf_pkg.sv
// shared types, codes and byte tables for the telemetry link framer
package tlf_pkg;

  // input operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_RX       = 3'd1;
  localparam logic [2:0] OP_SEND     = 3'd2;
  localparam logic [2:0] OP_RESET    = 3'd3;
  localparam logic [2:0] OP_IDENTIFY = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_VERDICT = 2'd1;
  localparam logic [1:0] KIND_CONNECT = 2'd2;

  // command codes passed from front to back
  localparam logic [1:0] CMD_VERDICT = 2'd0;
  localparam logic [1:0] CMD_CONNECT = 2'd1;
  localparam logic [1:0] CMD_FRAME   = 2'd2;
  localparam logic [1:0] CMD_IDENT   = 2'd3;

  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_M = 8'h4D;
  localparam logic [7:0] CHAR_O = 8'h4F;
  localparam logic [7:0] CHAR_K = 8'h4B;
  localparam logic [7:0] CHAR_W = 8'h57;

  localparam logic [15:0] ACK_WAIT_RESET = 16'd100;

  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] FRAME_LEN = 4'd9;
  localparam logic [IDX_W-1:0] IDENT_LEN = 4'd7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  code;
    logic        ack_ok;
    logic [15:0] seq;
    logic [7:0]  state_code;
    logic [31:0] payload;
  } cmd_t;

  // "Who" matcher text
  function automatic logic [7:0] hello_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = CHAR_W;
      2'd1:    c = 8'h68;
      2'd2:    c = 8'h6F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // identity text, newline terminated
  function automatic logic [7:0] ident_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = CHAR_B;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h74;
      4'd3:    c = CHAR_M;
      4'd4:    c = 8'h6F;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // telemetry frame bytes
  function automatic logic [7:0] frame_char(input cmd_t cmd, input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = CHAR_B;
      4'd1:    c = CHAR_M;
      4'd2:    c = cmd.seq[7:0];
      4'd3:    c = cmd.seq[15:8];
      4'd4:    c = cmd.state_code;
      4'd5:    c = cmd.payload[7:0];
      4'd6:    c = cmd.payload[15:8];
      4'd7:    c = cmd.payload[23:16];
      4'd8:    c = cmd.payload[31:24];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // number of result items a command produces
  function automatic logic [IDX_W-1:0] cmd_len(input logic [1:0] code);
    logic [IDX_W-1:0] n;
    unique case (code)
      CMD_FRAME: n = FRAME_LEN;
      CMD_IDENT: n = IDENT_LEN;
      default:   n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

// File: hdl/telemetry_link_framer.sv
// top level of the telemetry link framer
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  operation, rx_byte, state_code, payload
//   out      output     out_valid/out_stall  kind, tx_byte, ack_ok, last
//   cfg      input      cfg_write            cfg_data (ack wait ticks)
//
// an item is taken every cycle while the four-entry command queue has room
// the back end emits one result item per cycle unless out_stall holds it: a frame
// expands to nine items, an identity to seven, a verdict or connect to one;
// there is no clearing pass after reset
// reset is synchronous and clears the link state, the queue and the output
// out_stall holds the output register; the queue lets items keep coming
module telemetry_link_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  state_code,
  input  logic [31:0] payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic        ack_ok,
  output logic        last,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);
  import tlf_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_head;

  tlf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .rx_byte    (rx_byte),
    .state_code (state_code),
    .payload    (payload),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .queue_full (q_full),
    .push       (q_push),
    .push_cmd   (q_in)
  );

  tlf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  tlf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (q_empty),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .tx_byte     (tx_byte),
    .ack_ok      (ack_ok),
    .last        (last)
  );

`ifndef SYNTHESIS
  // front never issues a command into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command pushed into full queue");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // verdict and connect items are single and carry no byte
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_TX) |-> (last && tx_byte == 8'h00))
    else $error("non-byte result item malformed");

  // ack flag only on verdict items
  a_ack_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_VERDICT) |-> !ack_ok)
    else $error("ack flag outside verdict");
`endif

endmodule

// File: hdl/tlf_front.sv
// front end: accepts items, keeps link state and issues commands
module tlf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    operation,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    state_code,
  input  logic [31:0]   payload,
  input  logic          cfg_write,
  input  logic [15:0]   cfg_data,
  input  logic          queue_full,
  output logic          push,
  output tlf_pkg::cmd_t push_cmd
);
  import tlf_pkg::*;

  logic [15:0] ack_wait_ticks;
  logic [15:0] sequence_count, sequence_count_next;
  logic [1:0]  match_position, match_position_next;
  logic        ack_waiting, ack_waiting_next;
  logic [15:0] ack_timer, ack_timer_next;
  logic [1:0]  ack_bytes_seen, ack_bytes_seen_next;
  logic        ack_first_ok, ack_first_ok_next;
  logic        ack_second_ok, ack_second_ok_next;
  logic        accept;
  logic [1:0]  match_step;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // item decode and state update
  always_comb begin
    sequence_count_next = sequence_count;
    match_position_next = match_position;
    ack_waiting_next    = ack_waiting;
    ack_timer_next      = ack_timer;
    ack_bytes_seen_next = ack_bytes_seen;
    ack_first_ok_next   = ack_first_ok;
    ack_second_ok_next  = ack_second_ok;
    push                = 1'b0;
    push_cmd.code       = CMD_VERDICT;
    push_cmd.ack_ok     = 1'b0;
    push_cmd.seq        = sequence_count;
    push_cmd.state_code = state_code;
    push_cmd.payload    = payload;
    match_step          = 2'd0;

    if (match_position != 2'd3 && rx_byte == hello_char(match_position)) begin
      match_step = match_position + 2'd1;
    end else if (rx_byte == CHAR_W) begin
      match_step = 2'd1;
    end

    if (accept) begin
      unique case (operation)
        OP_TICK: begin
          if (ack_waiting) begin
            if (ack_timer > 16'd1) begin
              ack_timer_next = ack_timer - 16'd1;
            end else begin
              ack_timer_next   = 16'd0;
              ack_waiting_next = 1'b0;
              push             = 1'b1;
              push_cmd.code    = CMD_VERDICT;
              push_cmd.ack_ok  = (ack_bytes_seen == 2'd2) && ack_first_ok && ack_second_ok;
            end
          end
        end
        OP_RX: begin
          if (ack_waiting) begin
            if (ack_bytes_seen == 2'd0) begin
              ack_first_ok_next   = (rx_byte == CHAR_O);
              ack_bytes_seen_next = 2'd1;
            end else if (ack_bytes_seen == 2'd1) begin
              ack_second_ok_next  = (rx_byte == CHAR_K);
              ack_bytes_seen_next = 2'd2;
            end
          end else if (match_step == 2'd3) begin
            match_position_next = 2'd0;
            push                = 1'b1;
            push_cmd.code       = CMD_CONNECT;
          end else begin
            match_position_next = match_step;
          end
        end
        OP_SEND: begin
          push                = 1'b1;
          push_cmd.code       = CMD_FRAME;
          sequence_count_next = sequence_count + 16'd1;
          ack_waiting_next    = 1'b1;
          ack_timer_next      = (ack_wait_ticks == 16'd0) ? 16'd1 : ack_wait_ticks;
          ack_bytes_seen_next = 2'd0;
          ack_first_ok_next   = 1'b0;
          ack_second_ok_next  = 1'b0;
        end
        OP_RESET: begin
          sequence_count_next = 16'd0;
        end
        OP_IDENTIFY: begin
          push          = 1'b1;
          push_cmd.code = CMD_IDENT;
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_ticks <= ACK_WAIT_RESET;
      sequence_count <= 16'd0;
      match_position <= 2'd0;
      ack_waiting    <= 1'b0;
      ack_timer      <= 16'd0;
      ack_bytes_seen <= 2'd0;
      ack_first_ok   <= 1'b0;
      ack_second_ok  <= 1'b0;
    end else begin
      if (cfg_write) begin
        ack_wait_ticks <= cfg_data;
      end
      sequence_count <= sequence_count_next;
      match_position <= match_position_next;
      ack_waiting    <= ack_waiting_next;
      ack_timer      <= ack_timer_next;
      ack_bytes_seen <= ack_bytes_seen_next;
      ack_first_ok   <= ack_first_ok_next;
      ack_second_ok  <= ack_second_ok_next;
    end
  end

endmodule

// File: hdl/tlf_queue.sv
// short command queue between front and back
module tlf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tlf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tlf_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import tlf_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/tlf_back.sv
// back end: expands commands into result items, one per cycle unless out_stall holds
module tlf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_empty,
  input  tlf_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    kind,
  output logic [7:0]    tx_byte,
  output logic          ack_ok,
  output logic          last
);
  import tlf_pkg::*;

  cmd_t             cur;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             load_ok;
  logic             cur_last;
  logic             finishing;
  logic [1:0]       kind_next;
  logic [7:0]       tx_byte_next;
  logic             ack_ok_next;

  assign load_ok   = !out_valid || !out_stall;
  assign cur_last  = (idx == cmd_len(cur.code) - 4'd1);
  assign finishing = busy && load_ok && cur_last;
  assign pop       = !queue_empty && (!busy || finishing);

  // result item for the current step
  always_comb begin
    kind_next    = KIND_TX;
    tx_byte_next = 8'h00;
    ack_ok_next  = 1'b0;
    unique case (cur.code)
      CMD_VERDICT: begin
        kind_next   = KIND_VERDICT;
        ack_ok_next = cur.ack_ok;
      end
      CMD_CONNECT: begin
        kind_next = KIND_CONNECT;
      end
      CMD_FRAME: begin
        tx_byte_next = frame_char(cur, idx);
      end
      CMD_IDENT: begin
        tx_byte_next = ident_char(idx);
      end
    endcase
  end

  // current command
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (pop) begin
      cur <= head;
    end
  end

  // sequencer control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_ok) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (finishing) begin
        busy <= 1'b0;
      end else if (busy && load_ok) begin
        idx <= idx + 4'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_ok && busy) begin
      kind    <= kind_next;
      tx_byte <= tx_byte_next;
      ack_ok  <= ack_ok_next;
      last    <= cur_last;
    end
  end

endmodule
